// File: rtl/dmwbc_pkg.sv
// ============================================================================
// dmwbc_pkg: shared types and constants of the write-back cache
// Field widths, operation codes and the control/status bundles that run
// between the controller and the datapath.
// ============================================================================
package dmwbc_pkg;

    localparam int ADDR_W = 12;
    localparam int HALF_W = 64;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;     // clearing pass: zero one backing word and one line tag entry
        logic capture;   // take the input item and read the line store
        logic lookup;    // tag compare, victim write-back, write install, backing read
        logic fill;      // install the fetched word on a read miss
        logic out_load;  // load the output register
        logic out_held;  // output register takes the held result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_done;
        logic is_write;
        logic hit;
    } t_dp_sts;

endpackage

// File: rtl/dmwbc_ctrl.sv
// ============================================================================
// dmwbc_ctrl: sequencing controller
// Walks each item through lookup and an optional fill, owns the handshake
// and the output valid flag, and runs the clearing pass after reset.
// ============================================================================
module dmwbc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    input  dmwbc_pkg::t_dp_sts i_sts,
    output dmwbc_pkg::t_dp_cmd o_ctl
);
    import dmwbc_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_LOOKUP = 5'b00100,
        S_FILL   = 5'b01000,
        S_RESP   = 5'b10000
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    out_free;
    t_dp_cmd ctl;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        ctl     = '0;
        n_state = r_state;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ctl.clear = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    ctl.capture = 1'b1;
                    n_state     = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                ctl.lookup = 1'b1;
                if (!i_sts.is_write && !i_sts.hit) begin
                    n_state = S_FILL;
                end else if (out_free) begin
                    ctl.out_load = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_FILL: begin
                ctl.fill = 1'b1;
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    ctl.out_held = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_ctl   = ctl;

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result presented during clearing pass");

    a_fill_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> ($past(r_state) == S_LOOKUP))
        else $error("fill entered without a lookup");

    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_LOOKUP))
        else $error("accepted transfer did not start a lookup");

endmodule

// File: rtl/dmwbc_dpath.sv
// ============================================================================
// dmwbc_dpath: cache and backing memory datapath
// Holds the line store, backing memory, item, result and output registers.
// CACHE_LINES and MEM_WORDS must be powers of two; the block does not check.
// ============================================================================
module dmwbc_dpath #(
    parameter int CACHE_LINES = 64,
    parameter int MEM_WORDS   = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dmwbc_pkg::t_dp_cmd            i_ctl,
    output dmwbc_pkg::t_dp_sts            o_sts,
    input  logic                          i_cmd,
    input  logic [dmwbc_pkg::ADDR_W-1:0]  i_addr,
    input  logic [dmwbc_pkg::HALF_W-1:0]  i_wdata_lo,
    input  logic [dmwbc_pkg::HALF_W-1:0]  i_wdata_hi,
    output logic [dmwbc_pkg::HALF_W-1:0]  o_rdata_lo,
    output logic [dmwbc_pkg::HALF_W-1:0]  o_rdata_hi,
    output logic                          o_hit,
    output logic                          o_wrote_back,
    output logic [dmwbc_pkg::ADDR_W-1:0]  o_evicted_addr
);
    import dmwbc_pkg::*;

    localparam int LW    = $clog2(CACHE_LINES);
    localparam int MAW   = $clog2(MEM_WORDS);
    localparam int AW    = (MAW < ADDR_W) ? MAW : ADDR_W;
    localparam int TW    = (AW > LW) ? (AW - LW) : 1;
    localparam int SWEEP = (CACHE_LINES > MEM_WORDS) ? CACHE_LINES : MEM_WORDS;
    localparam int SW    = $clog2(SWEEP);

    typedef struct packed {
        logic          valid;
        logic          dirty;
        logic [TW-1:0] tag;
    } t_meta;

    typedef struct packed {
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] hi;
        logic              hit;
        logic              wb;
        logic [ADDR_W-1:0] evict;
    } t_res;

    t_meta             r_meta_mem [CACHE_LINES];
    logic [HALF_W-1:0] r_line_lo_mem [CACHE_LINES];
    logic [HALF_W-1:0] r_line_hi_mem [CACHE_LINES];
    logic [HALF_W-1:0] r_bk_lo_mem [MEM_WORDS];
    logic [HALF_W-1:0] r_bk_hi_mem [MEM_WORDS];

    logic [SW-1:0]     r_sweep;
    logic              r_write;
    logic [AW-1:0]     r_a;
    logic [HALF_W-1:0] r_wlo, r_whi;
    t_meta             r_meta;
    logic [HALF_W-1:0] r_line_lo, r_line_hi;
    logic [HALF_W-1:0] r_bk_lo, r_bk_hi;
    t_res              r_res, r_out;

    logic [AW-1:0]     in_a;
    logic [LW-1:0]     in_idx, idx;
    logic [TW-1:0]     tag;
    logic              hit, victim_dirty;
    logic [AW-1:0]     victim;
    t_res              res_now;
    logic              line_we;
    t_meta             line_meta;
    logic [HALF_W-1:0] line_lo, line_hi;
    logic              bk_we;
    logic [MAW-1:0]    bk_waddr;
    logic [HALF_W-1:0] bk_wlo, bk_whi;

    assign in_a   = AW'(i_addr);
    assign in_idx = LW'(in_a);
    assign idx    = LW'(r_a);
    assign tag    = TW'(r_a >> LW);

    assign hit          = r_meta.valid && (r_meta.tag == tag);
    assign victim_dirty = !hit && r_meta.dirty;
    assign victim       = AW'({r_meta.tag, idx});

    // In the fill cycle the flags come from the lookup that came before it.
    always_comb begin
        if (i_ctl.fill) begin
            res_now.lo    = r_bk_lo;
            res_now.hi    = r_bk_hi;
            res_now.hit   = r_res.hit;
            res_now.wb    = r_res.wb;
            res_now.evict = r_res.evict;
        end else begin
            res_now.lo    = (!r_write && hit) ? r_line_lo : '0;
            res_now.hi    = (!r_write && hit) ? r_line_hi : '0;
            res_now.hit   = hit;
            res_now.wb    = victim_dirty;
            res_now.evict = victim_dirty ? ADDR_W'(victim) : '0;
        end
    end

    // Line store: a write installs dirty, a read-miss fill installs clean.
    assign line_we         = (i_ctl.lookup && r_write) || i_ctl.fill;
    assign line_meta.valid = 1'b1;
    assign line_meta.dirty = r_write;
    assign line_meta.tag   = tag;
    assign line_lo         = r_write ? r_wlo : r_bk_lo;
    assign line_hi         = r_write ? r_whi : r_bk_hi;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_meta_mem[LW'(r_sweep)] <= '0;
        end else if (line_we) begin
            r_meta_mem[idx] <= line_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line_lo_mem[idx] <= line_lo;
            r_line_hi_mem[idx] <= line_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_meta    <= r_meta_mem[in_idx];
            r_line_lo <= r_line_lo_mem[in_idx];
            r_line_hi <= r_line_hi_mem[in_idx];
        end
    end

    // Backing memory: one write port (clear or victim) and one read port.
    assign bk_we    = i_ctl.clear || (i_ctl.lookup && victim_dirty);
    assign bk_waddr = i_ctl.clear ? MAW'(r_sweep) : MAW'(victim);
    assign bk_wlo   = i_ctl.clear ? '0 : r_line_lo;
    assign bk_whi   = i_ctl.clear ? '0 : r_line_hi;

    always_ff @(posedge i_clk) begin
        if (bk_we) begin
            r_bk_lo_mem[bk_waddr] <= bk_wlo;
            r_bk_hi_mem[bk_waddr] <= bk_whi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.lookup) begin
            r_bk_lo <= r_bk_lo_mem[MAW'(r_a)];
            r_bk_hi <= r_bk_hi_mem[MAW'(r_a)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_ctl.clear) begin
            r_sweep <= r_sweep + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_write <= (i_cmd == CMD_WRITE);
            r_a     <= in_a;
            r_wlo   <= i_wdata_lo;
            r_whi   <= i_wdata_hi;
        end
        if (i_ctl.lookup || i_ctl.fill) begin
            r_res <= res_now;
        end
        if (i_ctl.out_load) begin
            r_out <= i_ctl.out_held ? r_res : res_now;
        end
    end

    assign o_sts.sweep_done   = (r_sweep == SW'(SWEEP - 1));
    assign o_sts.is_write     = r_write;
    assign o_sts.hit          = hit;

    assign o_rdata_lo     = r_out.lo;
    assign o_rdata_hi     = r_out.hi;
    assign o_hit          = r_out.hit;
    assign o_wrote_back   = r_out.wb;
    assign o_evicted_addr = r_out.evict;

endmodule

// File: rtl/direct_mapped_writeback_cache.sv
// An input transfer registers the item and reads the line store; the lookup state then
// compares tags, writes back a dirty victim, reads the backing word and, for a read hit
// or any write, loads the output register or holds the result while the receiver is busy.
// A read miss adds the fill state, which installs the fetched word. Write-back and fetch
// overlap in lookup; a new item is taken only once the last result is in the output register.
// Reset: synchronous; a clearing pass then zeroes backing memory and line state, accepting no input.
// ============================================================================
// direct_mapped_writeback_cache: direct-mapped write-back write-allocate cache
// 128-bit words as two halves, in front of a backing word memory held inside.
// ============================================================================
module direct_mapped_writeback_cache #(
    parameter int CACHE_LINES = 64,
    parameter int MEM_WORDS   = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [dmwbc_pkg::ADDR_W-1:0]  i_addr,
    input  logic [dmwbc_pkg::HALF_W-1:0]  i_wdata_lo,
    input  logic [dmwbc_pkg::HALF_W-1:0]  i_wdata_hi,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dmwbc_pkg::HALF_W-1:0]  o_rdata_lo,
    output logic [dmwbc_pkg::HALF_W-1:0]  o_rdata_hi,
    output logic                          o_hit,
    output logic                          o_wrote_back,
    output logic [dmwbc_pkg::ADDR_W-1:0]  o_evicted_addr
);
    import dmwbc_pkg::*;

    t_dp_cmd ctl;
    t_dp_sts sts;

    dmwbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    dmwbc_dpath #(
        .CACHE_LINES (CACHE_LINES),
        .MEM_WORDS   (MEM_WORDS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cmd          (i_cmd),
        .i_addr         (i_addr),
        .i_wdata_lo     (i_wdata_lo),
        .i_wdata_hi     (i_wdata_hi),
        .o_rdata_lo     (o_rdata_lo),
        .o_rdata_hi     (o_rdata_hi),
        .o_hit          (o_hit),
        .o_wrote_back   (o_wrote_back),
        .o_evicted_addr (o_evicted_addr)
    );

    a_wb_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_wrote_back) |-> !o_hit)
        else $error("write-back reported on a hit");

    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_wrote_back) |-> (o_evicted_addr == '0))
        else $error("victim address reported without a write-back");

endmodule

// File: sim/dmwbc_checker.sv
// ============================================================================
// dmwbc_checker: result checker for the direct-mapped write-back cache
// Watches both channels, keeps its own copy of the cache lines and backing
// memory, predicts every result and compares the results field by field.
// ============================================================================
module dmwbc_checker #(
    parameter int CACHE_LINES = 64,
    parameter int MEM_WORDS   = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_cmd,
    input  logic [dmwbc_pkg::ADDR_W-1:0] i_addr,
    input  logic [dmwbc_pkg::HALF_W-1:0] i_wdata_lo,
    input  logic [dmwbc_pkg::HALF_W-1:0] i_wdata_hi,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [dmwbc_pkg::HALF_W-1:0] i_rdata_lo,
    input  logic [dmwbc_pkg::HALF_W-1:0] i_rdata_hi,
    input  logic                         i_hit,
    input  logic                         i_wrote_back,
    input  logic [dmwbc_pkg::ADDR_W-1:0] i_evicted_addr,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_hits,
    output int                           o_write_backs
);

    timeunit 1ns;
    timeprecision 1ps;

    import dmwbc_pkg::*;

    typedef struct packed {
        logic [HALF_W-1:0] rdata_lo;
        logic [HALF_W-1:0] rdata_hi;
        logic              hit;
        logic              wrote_back;
        logic [ADDR_W-1:0] evicted_addr;
    } t_access_result;

    logic              line_valid [CACHE_LINES];
    logic              line_dirty [CACHE_LINES];
    int                line_tag   [CACHE_LINES];
    logic [HALF_W-1:0] line_lo    [CACHE_LINES];
    logic [HALF_W-1:0] line_hi    [CACHE_LINES];
    logic [HALF_W-1:0] backing_lo [MEM_WORDS];
    logic [HALF_W-1:0] backing_hi [MEM_WORDS];

    t_access_result predicted_q[$];
    int             error_count;
    int             hit_count;
    int             write_back_count;

    // Applies one access to the cache copy and returns the result it yields.
    task automatic access_word(input logic cmd, input logic [ADDR_W-1:0] addr,
                               input logic [HALF_W-1:0] lo, input logic [HALF_W-1:0] hi,
                               output t_access_result res);
        int word;
        int idx;
        int tag;
        int victim;
        word = int'(addr) % MEM_WORDS;
        idx  = word % CACHE_LINES;
        tag  = word / CACHE_LINES;
        res  = '0;
        res.hit = line_valid[idx] && (line_tag[idx] == tag);
        if (!res.hit && line_dirty[idx]) begin
            victim = (line_tag[idx] * CACHE_LINES + idx) % MEM_WORDS;
            backing_lo[victim] = line_lo[idx];
            backing_hi[victim] = line_hi[idx];
            res.wrote_back   = 1'b1;
            res.evicted_addr = victim[ADDR_W-1:0];
        end
        if (cmd == CMD_WRITE) begin
            line_lo[idx]    = lo;
            line_hi[idx]    = hi;
            line_tag[idx]   = tag;
            line_valid[idx] = 1'b1;
            line_dirty[idx] = 1'b1;
        end else if (res.hit) begin
            res.rdata_lo = line_lo[idx];
            res.rdata_hi = line_hi[idx];
        end else begin
            res.rdata_lo    = backing_lo[word];
            res.rdata_hi    = backing_hi[word];
            line_lo[idx]    = res.rdata_lo;
            line_hi[idx]    = res.rdata_hi;
            line_tag[idx]   = tag;
            line_valid[idx] = 1'b1;
            line_dirty[idx] = 1'b0;
        end
    endtask

    function automatic int field_mismatch(string name, logic [HALF_W-1:0] exp_val,
                                          logic [HALF_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %h, actual %h", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_access_result exp_res;
        if (!i_rst_n) begin
            for (int i = 0; i < CACHE_LINES; i++) begin
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_tag[i]   = 0;
                line_lo[i]    = '0;
                line_hi[i]    = '0;
            end
            for (int i = 0; i < MEM_WORDS; i++) begin
                backing_lo[i] = '0;
                backing_hi[i] = '0;
            end
            predicted_q.delete();
            error_count      = 0;
            hit_count        = 0;
            write_back_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                access_word(i_cmd, i_addr, i_wdata_lo, i_wdata_hi, exp_res);
                predicted_q.push_back(exp_res);
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_q.size() == 0) begin
                    $error("result transfer with no access outstanding");
                    error_count++;
                end else begin
                    exp_res = predicted_q.pop_front();
                    error_count += field_mismatch("rdata_lo", exp_res.rdata_lo, i_rdata_lo);
                    error_count += field_mismatch("rdata_hi", exp_res.rdata_hi, i_rdata_hi);
                    error_count += field_mismatch("hit", HALF_W'(exp_res.hit),
                                                  HALF_W'(i_hit));
                    error_count += field_mismatch("wrote_back", HALF_W'(exp_res.wrote_back),
                                                  HALF_W'(i_wrote_back));
                    error_count += field_mismatch("evicted_addr",
                                                  HALF_W'(exp_res.evicted_addr),
                                                  HALF_W'(i_evicted_addr));
                    hit_count        += int'(exp_res.hit);
                    write_back_count += int'(exp_res.wrote_back);
                end
            end
        end
        o_errors      <= error_count;
        o_pending     <= predicted_q.size();
        o_hits        <= hit_count;
        o_write_backs <= write_back_count;
    end

endmodule

// File: sim/tb_direct_mapped_writeback_cache.sv
// ============================================================================
// tb_direct_mapped_writeback_cache: testbench of the write-back cache
// Drives directed and random read/write accesses under changing idle mixes
// and a long receiver hold-off; the checker predicts and compares results.
// ============================================================================
module tb_direct_mapped_writeback_cache;

    timeunit 1ns;
    timeprecision 1ps;

    import dmwbc_pkg::*;

    localparam int CACHE_LINES     = 64;
    localparam int MEM_WORDS       = 4096;
    localparam int TAG_MAX         = MEM_WORDS / CACHE_LINES - 1;
    localparam int ITEMS_PER_PHASE = 517;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 16;

    localparam logic [HALF_W-1:0] ONES   = '1;
    localparam logic [HALF_W-1:0] ZEROS  = '0;
    localparam logic [HALF_W-1:0] PAT_55 = {(HALF_W / 2){2'b01}};
    localparam logic [HALF_W-1:0] PAT_AA = {(HALF_W / 2){2'b10}};

    typedef enum logic [1:0] {
        PH_SENDER_LIGHT,
        PH_RECEIVER_LIGHT,
        PH_NO_IDLE
    } t_phase;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic              i_cmd      = CMD_READ;
    logic [ADDR_W-1:0] i_addr     = '0;
    logic [HALF_W-1:0] i_wdata_lo = '0;
    logic [HALF_W-1:0] i_wdata_hi = '0;
    logic              i_ready    = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [HALF_W-1:0] o_rdata_lo;
    logic [HALF_W-1:0] o_rdata_hi;
    logic              o_hit;
    logic              o_wrote_back;
    logic [ADDR_W-1:0] o_evicted_addr;

    int     error_count;
    int     pending_count;
    int     hit_count;
    int     write_back_count;
    t_phase phase     = PH_SENDER_LIGHT;
    int     rx_idle   = 45;
    int     tx_idle   = 24;
    int     hold_left = 0;
    logic   hold_done = 1'b0;
    int     sent_count = 0;
    int     quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    direct_mapped_writeback_cache #(
        .CACHE_LINES (CACHE_LINES),
        .MEM_WORDS   (MEM_WORDS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_addr         (i_addr),
        .i_wdata_lo     (i_wdata_lo),
        .i_wdata_hi     (i_wdata_hi),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_rdata_lo     (o_rdata_lo),
        .o_rdata_hi     (o_rdata_hi),
        .o_hit          (o_hit),
        .o_wrote_back   (o_wrote_back),
        .o_evicted_addr (o_evicted_addr)
    );

    dmwbc_checker #(
        .CACHE_LINES (CACHE_LINES),
        .MEM_WORDS   (MEM_WORDS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_cmd          (i_cmd),
        .i_addr         (i_addr),
        .i_wdata_lo     (i_wdata_lo),
        .i_wdata_hi     (i_wdata_hi),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_rdata_lo     (o_rdata_lo),
        .i_rdata_hi     (o_rdata_hi),
        .i_hit          (o_hit),
        .i_wrote_back   (o_wrote_back),
        .i_evicted_addr (o_evicted_addr),
        .o_errors       (error_count),
        .o_pending      (pending_count),
        .o_hits         (hit_count),
        .o_write_backs  (write_back_count)
    );

    // Result side: random stalls, plus one long hold-off when the no-idle
    // phase begins, so the cache backs up and drops o_ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (phase == PH_NO_IDLE && !hold_done) begin
            i_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_direct_mapped_writeback_cache: errors");
                $finish;
            end
        end
    end

    // Called just after a rising edge; returns just after the edge of the transfer.
    task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                               input logic [HALF_W-1:0] lo, input logic [HALF_W-1:0] hi);
        while ($urandom_range(0, 99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_addr     <= addr;
        i_wdata_lo <= lo;
        i_wdata_hi <= hi;
        do @(posedge i_clk); while (!o_ready);
        sent_count++;
    endtask

    task automatic send_random_access();
        int               tag;
        int               idx;
        logic [ADDR_W-1:0] addr;
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] hi;
        // Most accesses land on a small set of lines and tags so that hits,
        // dirty evictions and refetches of written-back words are common.
        if ($urandom_range(0, 9) < 6) begin
            tag  = $urandom_range(0, 1) ? $urandom_range(0, 2) : TAG_MAX - $urandom_range(0, 1);
            idx  = $urandom_range(0, 7) * 9;
            addr = ADDR_W'(tag * CACHE_LINES + idx);
        end else begin
            addr = ADDR_W'($urandom_range(0, MEM_WORDS - 1));
        end
        case ($urandom_range(0, 7))
            0: begin
                lo = ONES;
                hi = ONES;
            end
            1: begin
                lo = ZEROS;
                hi = ZEROS;
            end
            default: begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
        endcase
        send_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, addr, lo, hi);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-line read, hits, clean and dirty victims at both
        // ends of the address range, and refetches of written-back words.
        send_access(CMD_READ,  12'd0,    ZEROS,  ZEROS);
        send_access(CMD_WRITE, 12'd0,    ONES,   ONES);
        send_access(CMD_READ,  12'd0,    PAT_55, PAT_AA);
        send_access(CMD_WRITE, 12'd0,    PAT_55, PAT_AA);
        send_access(CMD_WRITE, 12'd64,   PAT_AA, PAT_55);
        send_access(CMD_READ,  12'd0,    ZEROS,  ZEROS);
        send_access(CMD_READ,  12'd64,   ZEROS,  ZEROS);
        send_access(CMD_WRITE, 12'd4095, ONES,   ONES);
        send_access(CMD_WRITE, 12'd4031, PAT_AA, PAT_AA);
        send_access(CMD_READ,  12'd4095, ZEROS,  ZEROS);
        send_access(CMD_WRITE, 12'd4095, ZEROS,  ZEROS);
        send_access(CMD_READ,  12'd4095, ONES,   ONES);
        send_access(CMD_READ,  12'd4031, ZEROS,  ZEROS);
        send_access(CMD_WRITE, 12'd2048, ZEROS,  ONES);
        send_access(CMD_READ,  12'd2048, ZEROS,  ZEROS);
        send_access(CMD_READ,  12'd63,   ZEROS,  ZEROS);
        send_access(CMD_WRITE, 12'd4032, PAT_55, PAT_55);
        send_access(CMD_READ,  12'd0,    ZEROS,  ZEROS);
        send_access(CMD_READ,  12'd4032, ZEROS,  ZEROS);

        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_random_access();
        end

        tx_idle = 45;
        phase   <= PH_RECEIVER_LIGHT;
        rx_idle <= 24;
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_random_access();
        end

        tx_idle = 0;
        phase   <= PH_NO_IDLE;
        rx_idle <= 0;
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_random_access();
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d accesses with %0d hits and %0d dirty write-backs,",
                 sent_count, hit_count, write_back_count);
        $display("under two idle mixes, no idling, and a %0d-cycle result hold-off.",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("tb_direct_mapped_writeback_cache: clean");
        end else begin
            $display("tb_direct_mapped_writeback_cache: errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/dmwbc_pkg.sv
rtl/dmwbc_ctrl.sv
rtl/dmwbc_dpath.sv
rtl/direct_mapped_writeback_cache.sv
sim/dmwbc_checker.sv
sim/tb_direct_mapped_writeback_cache.sv
